// ----- hw/rtl/cpsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsc_pkg: control pilot state classifier shared definitions
// Beat types, state codes, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
package cpsc_pkg;

	localparam int BLOCK_LEN_DEF = 8;
	localparam int SUM_W         = 16;
	localparam int SAMPLE_W      = 12;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	localparam logic [SAMPLE_W-1:0] MIDSCALE = 12'd2047;

	localparam logic [2:0] TWELVE_MAX   = 3'd5;
	localparam logic [2:0] TWELVE_LIMIT = 3'd3;

	localparam logic signed [SUM_W-1:0] THR_HIGH_RST = 16'sd11469;
	localparam logic signed [SUM_W-1:0] THR_MID_RST  = 16'sd8192;
	localparam logic signed [SUM_W-1:0] THR_LOW_RST  = 16'sd4916;
	localparam logic signed [SUM_W-1:0] THR_NEG_RST  = -16'sd11468;
	localparam logic [3:0]              FAULT_LIM_RST = 4'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_MID     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_NEG     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT = 3'd4;

	typedef enum logic [3:0] {
		PC_NONE      = 4'd0,
		PC_PWM12     = 4'd1,
		PC_PWM9      = 4'd2,
		PC_PWM6      = 4'd3,
		PC_PWM_PLUS  = 4'd4,
		PC_PWM_MINUS = 4'd5,
		PC_DC12      = 4'd6,
		PC_DC9       = 4'd7,
		PC_DC6       = 4'd8,
		PC_DC_ERR    = 4'd9
	} pilot_code_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] rising_sample;
		logic [SAMPLE_W-1:0] falling_sample;
		logic                pwm_active;
		logic                relay_closed;
	} in_t;

	typedef struct packed {
		logic [3:0] stable_state;
		logic [3:0] line_state;
		logic       pwm_level_error;
		logic       pwm_falling_error;
		logic       dc_level_error;
		logic       pilot_error;
		logic       step_fault;
		logic       error_six_to_twelve;
		logic       error_pwm_twelve;
		logic       force_dc;
	} out_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] thr_high;
		logic signed [SUM_W-1:0] thr_mid;
		logic signed [SUM_W-1:0] thr_low;
		logic signed [SUM_W-1:0] thr_negative;
		logic [3:0]              fault_limit;
	} cfg_t;

	typedef struct packed {
		logic pwm_level;
		logic pwm_fall;
		logic dc_level;
		logic pilot;
		logic step_fault;
		logic six_twelve;
		logic pwm_twelve;
	} flags_t;

	// center an ADC code around midscale
	function automatic logic signed [SAMPLE_W:0] center(input logic [SAMPLE_W-1:0] code);
		center = $signed({1'b0, code}) - $signed({1'b0, MIDSCALE});
	endfunction

	// signed 16-bit add with saturation
	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SAMPLE_W:0] b
	);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {{(SUM_W-SAMPLE_W){b[SAMPLE_W]}}, b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sat_add = s[SUM_W-1:0];
		end
	endfunction

endpackage

// ----- hw/rtl/control_pilot_state_classifier_unit.sv -----
`timescale 1ns / 1ps
// Result path: input register, then result register, from an accepted
// input beat to its result beat.
// Throughput: one sample beat per cycle unless the output stalls; the state
// update is one add-compare pass between the input and result registers.
// Reset: asynchronous, active low; clears sums, counters, state codes and
// sticky flags, and loads the register reset values.
// ----------------------------------------------------------------------------
// control_pilot_state_classifier_unit: control pilot state classifier
// Block-sums pilot samples, classifies levels and tracks stable pilot state.
// ----------------------------------------------------------------------------
module control_pilot_state_classifier_unit #(
	parameter int BLOCK_LEN = cpsc_pkg::BLOCK_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  cpsc_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output cpsc_pkg::out_t                  out_data,
	input  logic                            cfg_we,
	input  logic [cpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpsc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cpsc_pkg::*;

	cfg_t  cfg;
	in_t   item_s1;
	logic  valid_s1;
	out_t  res_s2;
	logic  valid_s2;
	out_t  result;
	logic  adv_s2;
	logic  step;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign step     = valid_s1 && adv_s2;

	cpsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cpsc_core #(
		.BLOCK_LEN (BLOCK_LEN)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// input register: load a new beat whenever the stage is free or drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_step_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("processed beat did not reach the result register");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> valid_s2)
		else $error("pending result dropped while stalled");

endmodule

// ----- hw/rtl/cpsc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsc_cfg: configuration registers
// Thresholds and fault limit, written by index through the plain write port.
// ----------------------------------------------------------------------------
module cpsc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpsc_pkg::CFG_DATA_W-1:0] cfg_data,
	output cpsc_pkg::cfg_t                 cfg
);
	import cpsc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_high     <= THR_HIGH_RST;
			cfg_q.thr_mid      <= THR_MID_RST;
			cfg_q.thr_low      <= THR_LOW_RST;
			cfg_q.thr_negative <= THR_NEG_RST;
			cfg_q.fault_limit  <= FAULT_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THR_HIGH:    cfg_q.thr_high     <= cfg_data;
				CFG_THR_MID:     cfg_q.thr_mid      <= cfg_data;
				CFG_THR_LOW:     cfg_q.thr_low      <= cfg_data;
				CFG_THR_NEG:     cfg_q.thr_negative <= cfg_data;
				CFG_FAULT_LIMIT: cfg_q.fault_limit  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/cpsc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsc_core: block accumulation, classification and state tracking
// Updates all state for one sample beat per step and forms its result.
// ----------------------------------------------------------------------------
module cpsc_core #(
	parameter int BLOCK_LEN = cpsc_pkg::BLOCK_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  cpsc_pkg::in_t  item,
	input  cpsc_pkg::cfg_t cfg,
	output cpsc_pkg::out_t result
);
	import cpsc_pkg::*;

	localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);

	logic signed [SUM_W-1:0] rsum_q, rsum_d, fsum_q, fsum_d;
	logic [CNT_W-1:0]        pcnt_q, pcnt_d, dcnt_q, dcnt_d;
	pilot_code_t             prev_q, prev_d, older_q, older_d;
	pilot_code_t             stable_q, stable_d, line_q, line_d;
	logic [3:0]              dis_q, dis_d;
	logic [2:0]              tw_q, tw_d;
	logic                    saw6_q, saw6_d;
	flags_t                  flags_q, flags_d;

	logic signed [SAMPLE_W:0]  rs, fs;
	logic signed [SUM_W-1:0]   rsum_sat, fsum_sat;
	logic                      force_dc;

	assign rs       = center(item.rising_sample);
	assign fs       = center(item.falling_sample);
	assign rsum_sat = sat_add(rsum_q, rs);
	assign fsum_sat = sat_add(fsum_q, fs);

	always_comb begin
		pilot_code_t now;
		logic        blk;
		rsum_d   = rsum_q;
		fsum_d   = fsum_q;
		pcnt_d   = pcnt_q;
		dcnt_d   = dcnt_q;
		prev_d   = prev_q;
		older_d  = older_q;
		stable_d = stable_q;
		line_d   = line_q;
		dis_d    = dis_q;
		tw_d     = tw_q;
		saw6_d   = saw6_q;
		flags_d  = flags_q;
		now      = PC_NONE;
		blk      = 1'b0;

		if (item.pwm_active) begin
			dcnt_d = '0;
			rsum_d = rsum_sat;
			fsum_d = fsum_sat;
			if (pcnt_q == CNT_LAST) begin
				pcnt_d = '0;
				blk    = 1'b1;
				if (rsum_sat >= cfg.thr_high) begin
					now = PC_PWM12;
				end else if (rsum_sat >= cfg.thr_mid) begin
					now = PC_PWM9;
				end else if (rsum_sat >= cfg.thr_low) begin
					now = PC_PWM6;
				end else begin
					now = PC_PWM_PLUS;
					flags_d.pwm_level = 1'b1;
				end
				// falling level failure overrides the rising class
				if (!(fsum_sat < cfg.thr_negative)) begin
					now = PC_PWM_MINUS;
					flags_d.pwm_fall = 1'b1;
				end
				rsum_d = '0;
				fsum_d = '0;
			end else begin
				pcnt_d = pcnt_q + 1'b1;
			end
		end else begin
			pcnt_d = '0;
			rsum_d = rsum_sat;
			if (dcnt_q == CNT_LAST) begin
				dcnt_d = '0;
				blk    = 1'b1;
				if (rsum_sat >= cfg.thr_high) begin
					now = PC_DC12;
				end else if (rsum_sat >= cfg.thr_mid) begin
					now = PC_DC9;
				end else if (rsum_sat >= cfg.thr_low) begin
					now = PC_DC6;
				end else begin
					now = PC_DC_ERR;
					flags_d.dc_level = 1'b1;
				end
				rsum_d = '0;
			end else begin
				dcnt_d = dcnt_q + 1'b1;
			end
		end

		// three agreeing block classes make the stable state
		if (blk) begin
			if (older_q == prev_q && prev_q == now) begin
				stable_d = now;
				dis_d    = '0;
				if (now == PC_PWM_PLUS || now == PC_PWM_MINUS || now == PC_DC_ERR) begin
					flags_d.pilot = 1'b1;
				end
			end else if (dis_q < cfg.fault_limit) begin
				dis_d = dis_q + 1'b1;
			end else begin
				flags_d.step_fault = 1'b1;
			end
			older_d = prev_q;
			prev_d  = now;
		end

		if (item.pwm_active) begin
			if (stable_d == PC_PWM12) begin
				if (tw_q < TWELVE_MAX) begin
					tw_d = tw_q + 1'b1;
				end
			end else begin
				tw_d = '0;
			end
			if (stable_d == PC_PWM6) begin
				saw6_d = 1'b1;
			end else if (stable_d == PC_PWM9 || stable_d == PC_DC9 || stable_d == PC_DC12) begin
				saw6_d = 1'b0;
			end
			if (stable_d == PC_PWM12 && saw6_q) begin
				flags_d.six_twelve = 1'b1;
			end
		end

		if (stable_d == PC_DC12 || stable_d == PC_DC9 || stable_d == PC_PWM9 ||
		    stable_d == PC_PWM6) begin
			line_d = stable_d;
		end

		force_dc = (stable_d == PC_PWM12) && (tw_d > TWELVE_LIMIT) && item.relay_closed;
		if (force_dc) begin
			flags_d.pwm_twelve = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsum_q   <= '0;
			fsum_q   <= '0;
			pcnt_q   <= '0;
			dcnt_q   <= '0;
			prev_q   <= PC_NONE;
			older_q  <= PC_NONE;
			stable_q <= PC_NONE;
			line_q   <= PC_NONE;
			dis_q    <= '0;
			tw_q     <= '0;
			saw6_q   <= 1'b0;
			flags_q  <= '0;
		end else if (step) begin
			rsum_q   <= rsum_d;
			fsum_q   <= fsum_d;
			pcnt_q   <= pcnt_d;
			dcnt_q   <= dcnt_d;
			prev_q   <= prev_d;
			older_q  <= older_d;
			stable_q <= stable_d;
			line_q   <= line_d;
			dis_q    <= dis_d;
			tw_q     <= tw_d;
			saw6_q   <= saw6_d;
			flags_q  <= flags_d;
		end
	end

	always_comb begin
		result.stable_state        = stable_d;
		result.line_state          = line_d;
		result.pwm_level_error     = flags_d.pwm_level;
		result.pwm_falling_error   = flags_d.pwm_fall;
		result.dc_level_error      = flags_d.dc_level;
		result.pilot_error         = flags_d.pilot;
		result.step_fault          = flags_d.step_fault;
		result.error_six_to_twelve = flags_d.six_twelve;
		result.error_pwm_twelve    = flags_d.pwm_twelve;
		result.force_dc            = force_dc;
	end

	a_tw_sat: assert property (@(posedge clk) disable iff (!arst_n)
		tw_q <= TWELVE_MAX)
		else $error("persisted 12 V counter beyond its limit");

	a_stable_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(stable_q != $past(stable_q)) |-> (prev_q == stable_q && older_q == stable_q))
		else $error("stable state changed without three agreeing blocks");

	a_line_codes: assert property (@(posedge clk) disable iff (!arst_n)
		line_q == PC_NONE || line_q == PC_DC12 || line_q == PC_DC9 ||
		line_q == PC_PWM9 || line_q == PC_PWM6)
		else $error("line state holds a code that is not a line level");

	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(pcnt_q == '0 && dcnt_q == '0 && $past(step)) |-> (rsum_q == '0))
		else $error("rising sum not cleared at block boundary");

endmodule

// ----- bench/pilot_state_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pilot_state_checker: pilot classifier beat checker
// Watches the sample, result and register ports of the classifier. Each
// accepted sample beat updates an independent model of the block-sum
// classifier and queues the result it should produce. Each accepted result
// beat is compared field by field against the oldest queued one. The module
// reports a mismatch count and the number of results still owed.
// ----------------------------------------------------------------------------
module pilot_state_checker #(
	parameter int BLOCK_LEN = cpsc_pkg::BLOCK_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  cpsc_pkg::in_t                   in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  cpsc_pkg::out_t                  out_data,
	input  logic                            cfg_we,
	input  logic [cpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpsc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              states_due
);
	import cpsc_pkg::*;

	localparam int ACC_MAX   = 32767;
	localparam int ACC_MIN   = -32768;

	cfg_t                    cfg;
	logic signed [SUM_W-1:0] rise_acc;
	logic signed [SUM_W-1:0] fall_acc;
	int                      pwm_cnt;
	int                      dc_cnt;
	pilot_code_t             last_cls;
	pilot_code_t             prior_cls;
	pilot_code_t             stable;
	pilot_code_t             line;
	logic [3:0]              miss_cnt;
	logic [2:0]              twelve_run;
	logic                    six_mark;
	flags_t                  sticky;

	out_t                    owed_states[$];

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
		if (got !== want) begin
			report_mismatch(name, int'(got), int'(want));
		end
	endtask

	function automatic logic signed [SUM_W-1:0] clamp_add(
		logic signed [SUM_W-1:0] acc,
		int                      delta
	);
		int total;
		total = int'(acc) + delta;
		if (total > ACC_MAX) total = ACC_MAX;
		if (total < ACC_MIN) total = ACC_MIN;
		return SUM_W'(total);
	endfunction

	function automatic void clear_model();
		cfg.thr_high     = THR_HIGH_RST;
		cfg.thr_mid      = THR_MID_RST;
		cfg.thr_low      = THR_LOW_RST;
		cfg.thr_negative = THR_NEG_RST;
		cfg.fault_limit  = FAULT_LIM_RST;
		rise_acc   = '0;
		fall_acc   = '0;
		pwm_cnt    = 0;
		dc_cnt     = 0;
		last_cls   = PC_NONE;
		prior_cls  = PC_NONE;
		stable     = PC_NONE;
		line       = PC_NONE;
		miss_cnt   = '0;
		twelve_run = '0;
		six_mark   = 1'b0;
		sticky     = '0;
	endfunction

	// three agreeing classes promote it; else a miss, or a step fault at limit
	function automatic void close_block(pilot_code_t now, pilot_code_t err_a,
		pilot_code_t err_b);
		if (prior_cls == last_cls && last_cls == now) begin
			stable   = now;
			miss_cnt = '0;
			if (now == err_a || now == err_b) sticky.pilot = 1'b1;
		end else if (miss_cnt < cfg.fault_limit) begin
			miss_cnt++;
		end else begin
			sticky.step_fault = 1'b1;
		end
		prior_cls = last_cls;
		last_cls  = now;
	endfunction

	function automatic out_t advance_pilot(in_t beat);
		int          rise_c;
		int          fall_c;
		logic        force_req;
		pilot_code_t now;
		out_t        res;
		rise_c = int'(beat.rising_sample) - int'(MIDSCALE);
		fall_c = int'(beat.falling_sample) - int'(MIDSCALE);
		if (beat.pwm_active) begin
			dc_cnt   = 0;
			fall_acc = clamp_add(fall_acc, fall_c);
			rise_acc = clamp_add(rise_acc, rise_c);
			pwm_cnt++;
			if (pwm_cnt >= BLOCK_LEN) begin
				pwm_cnt = 0;
				if (rise_acc >= $signed(cfg.thr_high)) begin
					now = PC_PWM12;
				end else if (rise_acc >= $signed(cfg.thr_mid)) begin
					now = PC_PWM9;
				end else if (rise_acc >= $signed(cfg.thr_low)) begin
					now = PC_PWM6;
				end else begin
					now = PC_PWM_PLUS;
					sticky.pwm_level = 1'b1;
				end
				rise_acc = '0;
				// a bad low level overrides whatever the high level said
				if (!(fall_acc < $signed(cfg.thr_negative))) begin
					now = PC_PWM_MINUS;
					sticky.pwm_fall = 1'b1;
				end
				fall_acc = '0;
				close_block(now, PC_PWM_PLUS, PC_PWM_MINUS);
			end
			if (stable == PC_PWM12) begin
				if (twelve_run < TWELVE_MAX) twelve_run++;
			end else begin
				twelve_run = '0;
			end
			if (stable == PC_PWM6) begin
				six_mark = 1'b1;
			end else if (stable == PC_PWM9 || stable == PC_DC9 || stable == PC_DC12) begin
				six_mark = 1'b0;
			end
			if (stable == PC_PWM12 && six_mark) sticky.six_twelve = 1'b1;
		end else begin
			// DC shares the rising sum but leaves the falling sum alone
			pwm_cnt  = 0;
			rise_acc = clamp_add(rise_acc, rise_c);
			dc_cnt++;
			if (dc_cnt >= BLOCK_LEN) begin
				dc_cnt = 0;
				if (rise_acc >= $signed(cfg.thr_high)) begin
					now = PC_DC12;
				end else if (rise_acc >= $signed(cfg.thr_mid)) begin
					now = PC_DC9;
				end else if (rise_acc >= $signed(cfg.thr_low)) begin
					now = PC_DC6;
				end else begin
					now = PC_DC_ERR;
					sticky.dc_level = 1'b1;
				end
				rise_acc = '0;
				close_block(now, PC_DC_ERR, PC_DC_ERR);
			end
		end

		if (stable == PC_DC12 || stable == PC_DC9 || stable == PC_PWM9 || stable == PC_PWM6) begin
			line = stable;
		end

		force_req = (stable == PC_PWM12) && (twelve_run > TWELVE_LIMIT) && beat.relay_closed;
		if (force_req) sticky.pwm_twelve = 1'b1;

		res.stable_state        = stable;
		res.line_state          = line;
		res.pwm_level_error     = sticky.pwm_level;
		res.pwm_falling_error   = sticky.pwm_fall;
		res.dc_level_error      = sticky.dc_level;
		res.pilot_error         = sticky.pilot;
		res.step_fault          = sticky.step_fault;
		res.error_six_to_twelve = sticky.six_twelve;
		res.error_pwm_twelve    = sticky.pwm_twelve;
		res.force_dc            = force_req;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_t want;
		if (!arst_n) begin
			clear_model();
			owed_states.delete();
			mismatches = 0;
			states_due = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_THR_HIGH:    cfg.thr_high     = cfg_data;
					CFG_THR_MID:     cfg.thr_mid      = cfg_data;
					CFG_THR_LOW:     cfg.thr_low      = cfg_data;
					CFG_THR_NEG:     cfg.thr_negative = cfg_data;
					CFG_FAULT_LIMIT: cfg.fault_limit  = cfg_data[3:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (owed_states.size() == 0) begin
					report_mismatch("result beat with nothing outstanding", int'(out_data), -1);
				end else begin
					want = owed_states.pop_front();
					check_field("stable_state", out_data.stable_state, want.stable_state);
					check_field("line_state", out_data.line_state, want.line_state);
					check_field("pwm_level_error", out_data.pwm_level_error,
						want.pwm_level_error);
					check_field("pwm_falling_error", out_data.pwm_falling_error,
						want.pwm_falling_error);
					check_field("dc_level_error", out_data.dc_level_error,
						want.dc_level_error);
					check_field("pilot_error", out_data.pilot_error, want.pilot_error);
					check_field("step_fault", out_data.step_fault, want.step_fault);
					check_field("error_six_to_twelve", out_data.error_six_to_twelve,
						want.error_six_to_twelve);
					check_field("error_pwm_twelve", out_data.error_pwm_twelve,
						want.error_pwm_twelve);
					check_field("force_dc", out_data.force_dc, want.force_dc);
				end
			end
			if (in_valid && !in_stall) begin
				owed_states.push_back(advance_pilot(in_data));
			end
			states_due = owed_states.size();
		end
	end

endmodule

// ----- bench/tb_control_pilot_state_classifier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_control_pilot_state_classifier_unit: pilot classifier testbench
// Drives sample beats into the classifier: a short directed opening with
// both PWM error checks and sum saturation, then phases of random runs
// under several threshold settings. Most runs hold a pilot level for whole
// blocks so stable states, the fault counter and the 12 V checks are
// reached; the rest is noise and mode-swinging bursts. Both ports idle at
// random. A side checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_control_pilot_state_classifier_unit;
	import cpsc_pkg::*;

	localparam int BLOCK       = BLOCK_LEN_DEF;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 120;
	localparam int THR_MAX     = 16384;
	localparam int THR_MIN     = -16376;
	localparam int CODE_MAX    = 4095;
	localparam int DRAIN_LIMIT = 4000;
	localparam int TAIL_CYCLES = 8;
	localparam int TIMEOUT_NS  = 2000000;

	typedef enum int {BAND_TWELVE, BAND_NINE, BAND_SIX, BAND_LOW} band_t;
	typedef enum int {RUN_LEVEL, RUN_NOISE, RUN_SWING} run_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	in_t                   in_data      = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	out_t                  out_data;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	int                    mismatches;
	int                    states_due;

	cfg_t                  shadow;
	int                    sent         = 0;
	int                    pwm_fill     = 0;
	int                    dc_fill      = 0;
	logic                  steady_feed  = 1'b0;
	logic                  steady_drain = 1'b0;

	control_pilot_state_classifier_unit #(
		.BLOCK_LEN(BLOCK)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	pilot_state_checker #(
		.BLOCK_LEN(BLOCK)
	) watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.states_due(states_due)
	);

	always #2 clk = ~clk;

	function automatic int per_sample(logic signed [SUM_W-1:0] thr);
		return int'(thr) / BLOCK;
	endfunction

	function automatic logic [SAMPLE_W-1:0] to_code(int level);
		int mid;
		mid = int'(MIDSCALE);
		if (level < -mid) level = -mid;
		if (level > CODE_MAX - mid) level = CODE_MAX - mid;
		return SAMPLE_W'(level + mid);
	endfunction

	task automatic send_beat(in_t beat);
		int gap;
		gap = steady_feed ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (in_stall);
		sent++;
		// track block position per mode so level runs can line up with blocks
		if (beat.pwm_active) begin
			dc_fill  = 0;
			pwm_fill = (pwm_fill + 1) % BLOCK;
		end else begin
			pwm_fill = 0;
			dc_fill  = (dc_fill + 1) % BLOCK;
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (states_due != 0);
	endtask

	initial begin : drain
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 24) == 0) steady_drain = ~steady_drain;
			hold = steady_drain ? 0 : $urandom_range(0, 4);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		in_t   beat;
		cfg_t  next;
		run_t  kind;
		band_t band;
		int    target, len, rise_v, fall_v, runs, guard, span, r, fill;
		logic  pwm, relay, high_side;

		shadow = '{THR_HIGH_RST, THR_MID_RST, THR_LOW_RST, THR_NEG_RST, FAULT_LIM_RST};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// one PWM block with a low high level and a high low level: both errors
		for (int i = 0; i < BLOCK; i++) begin
			beat.rising_sample  = (i == 0) ? SAMPLE_W'(CODE_MAX) : '0;
			beat.falling_sample = SAMPLE_W'(CODE_MAX);
			beat.pwm_active     = 1'b1;
			beat.relay_closed   = i[0];
			send_beat(beat);
		end
		// swing modes every beat: no block closes, the shared sum pins at its floor
		for (int i = 0; i < 17; i++) begin
			beat.rising_sample  = '0;
			beat.falling_sample = '0;
			beat.pwm_active     = i[0];
			beat.relay_closed   = ~i[0];
			send_beat(beat);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: next = '{THR_HIGH_RST, THR_MID_RST, THR_LOW_RST, THR_NEG_RST, FAULT_LIM_RST};
				1: next = '{SUM_W'(THR_MAX), SUM_W'(THR_MAX), SUM_W'(THR_MAX),
					SUM_W'(THR_MIN), 4'd0};
				2: next = '{SUM_W'(THR_MIN), SUM_W'(THR_MIN), SUM_W'(THR_MIN),
					SUM_W'(THR_MAX), 4'd15};
				3: begin
					next.thr_high     = SUM_W'($urandom_range(9000, THR_MAX));
					next.thr_mid      = next.thr_high - SUM_W'($urandom_range(1000, 4000));
					next.thr_low      = next.thr_mid - SUM_W'($urandom_range(1000, 4000));
					next.thr_negative = SUM_W'(-int'($urandom_range(6000, -THR_MIN)));
					next.fault_limit  = 4'($urandom_range(0, 15));
				end
				4: begin
					// any order of thresholds is legal
					next.thr_high     = SUM_W'(int'($urandom_range(0, THR_MAX - THR_MIN)) + THR_MIN);
					next.thr_mid      = SUM_W'(int'($urandom_range(0, THR_MAX - THR_MIN)) + THR_MIN);
					next.thr_low      = SUM_W'(int'($urandom_range(0, THR_MAX - THR_MIN)) + THR_MIN);
					next.thr_negative = SUM_W'(int'($urandom_range(0, THR_MAX - THR_MIN)) + THR_MIN);
					next.fault_limit  = 4'($urandom_range(0, 15));
				end
				default: next = '{THR_HIGH_RST, THR_MID_RST, THR_LOW_RST, THR_NEG_RST, 4'd1};
			endcase

			wait_idle();
			shadow = next;
			cfg_we    <= 1'b1;
			cfg_index <= CFG_THR_HIGH;
			cfg_data  <= next.thr_high;
			@(posedge clk);
			cfg_index <= CFG_THR_MID;
			cfg_data  <= next.thr_mid;
			@(posedge clk);
			cfg_index <= CFG_THR_LOW;
			cfg_data  <= next.thr_low;
			@(posedge clk);
			cfg_index <= CFG_THR_NEG;
			cfg_data  <= next.thr_negative;
			@(posedge clk);
			cfg_index <= CFG_FAULT_LIMIT;
			cfg_data  <= {12'($urandom), next.fault_limit};
			@(posedge clk);
			// indexes past the last register must be dropped
			cfg_index <= CFG_FAULT_LIMIT + CFG_IDX_W'($urandom_range(1, 3));
			cfg_data  <= CFG_DATA_W'($urandom);
			@(posedge clk);
			cfg_we    <= 1'b0;

			target = sent + PHASE_ITEMS;
			runs   = 0;
			while (sent < target) begin
				runs++;
				steady_feed = ($urandom_range(0, 3) == 0);
				// on the fourth run, hold off until every result has drained
				if (runs == 4) wait_idle();
				r = $urandom_range(0, 19);
				kind = (r < 14) ? RUN_LEVEL : (r < 17) ? RUN_NOISE : RUN_SWING;
				case (kind)
					RUN_LEVEL: begin
						pwm   = ($urandom_range(0, 9) < 6);
						band  = band_t'($urandom_range(0, 3));
						relay = ($urandom_range(0, 3) != 0);
						case (band)
							BAND_TWELVE: begin
								rise_v = per_sample(shadow.thr_high) + 6 + $urandom_range(0, 60);
							end
							BAND_NINE: begin
								span = per_sample(shadow.thr_high) - per_sample(shadow.thr_mid) - 12;
								rise_v = per_sample(shadow.thr_mid) + 6
									+ $urandom_range(0, (span > 0) ? span : 0);
							end
							BAND_SIX: begin
								span = per_sample(shadow.thr_mid) - per_sample(shadow.thr_low) - 12;
								rise_v = per_sample(shadow.thr_low) + 6
									+ $urandom_range(0, (span > 0) ? span : 0);
							end
							default: begin
								rise_v = per_sample(shadow.thr_low) - 6 - int'($urandom_range(0, 600));
							end
						endcase
						if ($urandom_range(0, 9) == 0) begin
							fall_v = per_sample(shadow.thr_negative) + 6 + $urandom_range(0, 800);
						end else begin
							fall_v = per_sample(shadow.thr_negative) - 6
								- int'($urandom_range(0, 200));
						end
						// finish a partly filled block before the whole ones
						fill = pwm ? pwm_fill : dc_fill;
						len  = $urandom_range(3, 5) * BLOCK + ((fill == 0) ? 0 : BLOCK - fill);
						repeat (len) begin
							beat.rising_sample  = to_code(rise_v + int'($urandom_range(0, 8)) - 4);
							beat.falling_sample = to_code(fall_v + int'($urandom_range(0, 8)) - 4);
							beat.pwm_active     = pwm;
							beat.relay_closed   = relay;
							send_beat(beat);
						end
					end
					RUN_NOISE: begin
						len = $urandom_range(8, 24);
						repeat (len) begin
							beat.rising_sample  = SAMPLE_W'($urandom);
							beat.falling_sample = SAMPLE_W'($urandom);
							beat.pwm_active     = 1'($urandom);
							beat.relay_closed   = 1'($urandom);
							send_beat(beat);
						end
					end
					default: begin
						// mode swings keep blocks open and drive the sum into saturation
						len       = $urandom_range(16, 24);
						high_side = 1'($urandom);
						pwm       = 1'($urandom);
						repeat (len) begin
							beat.rising_sample  = high_side ? SAMPLE_W'(CODE_MAX) : '0;
							beat.falling_sample = SAMPLE_W'($urandom);
							beat.pwm_active     = pwm;
							beat.relay_closed   = 1'($urandom);
							send_beat(beat);
							pwm = ~pwm;
						end
					end
				endcase
			end
		end

		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (states_due != 0 && guard < DRAIN_LIMIT);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && states_due == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin : watchdog
		#TIMEOUT_NS;
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/cpsc_pkg.sv
hw/rtl/cpsc_cfg.sv
hw/rtl/cpsc_core.sv
hw/rtl/control_pilot_state_classifier_unit.sv
bench/pilot_state_checker.sv
bench/tb_control_pilot_state_classifier_unit.sv
